// File: sv/assert_macros.svh
// assertion macros shared by the sampler rtl
// no dependencies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off during reset
`define MOS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check, always on
`define MOS_ASSERT_ON(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/mos_pkg.sv
// types, constants and the exp table for the orbital sampler step
// no dependencies

package mos_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 24;
  localparam int RAD_W     = 2 * COORD_W;
  localparam int ROOT_W    = COORD_W;
  localparam int TI_W      = $clog2(FRAC_BITS + 1);
  localparam int K_W       = $clog2(FRAC_BITS + 2);

  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic signed [23:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] COORD_MIN = 24'sh800000;
  localparam int SH_UNIF  = 15;
  localparam int SH_GAUSS = 12;

  localparam logic [1:0] REG_STEP_LENGTH   = 2'd0;
  localparam logic [1:0] REG_PROPOSAL_MODE = 2'd1;
  localparam logic [1:0] REG_TARGET_SELECT = 2'd2;
  localparam logic [1:0] REG_START_COORD   = 2'd3;

  typedef struct packed {
    logic               restart;
    logic signed [15:0] draw_x;
    logic signed [15:0] draw_y;
    logic signed [15:0] draw_z;
    logic [15:0]        accept_draw;
  } in_req_t;

  typedef struct packed {
    logic [23:0]        radius_before;
    logic               accepted;
    logic signed [23:0] new_x;
    logic signed [23:0] new_y;
    logic signed [23:0] new_z;
  } out_rsp_t;

  typedef struct packed {
    logic [22:0]        step_length;
    logic               proposal_mode;
    logic               target_select;
    logic signed [23:0] start_coord;
  } cfg_t;

  typedef logic [FRAC_BITS:0][31:0] ttab_t;

  function automatic logic [63:0] isqrt_c(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    x = v;
    for (int i = 0; i < 32; i++) begin
      if (b > x) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // t[k] ~ 2^(-2^-k) in q0.32
  function automatic ttab_t gen_ttab();
    ttab_t t;
    logic [63:0] s;
    t[0] = 32'h8000_0000;
    for (int k = 1; k <= FRAC_BITS; k++) begin
      s = isqrt_c({t[k-1], 32'h0});
      t[k] = s[31:0];
    end
    return t;
  endfunction

  localparam ttab_t T_TAB = gen_ttab();

endpackage

// File: sv/mos_mul.sv
// shared 32x32 unsigned multiplier with registered product
// no dependencies

module mos_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// File: sv/mos_isqrt.sv
// iterative integer square root, one root bit per cycle
// depends on mos_pkg

module mos_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mos_pkg::RAD_W-1:0]   rad_i,
  output logic                        done_o,
  output logic [mos_pkg::ROOT_W-1:0]  root_o
);

  localparam int CNT_W = $clog2(mos_pkg::ROOT_W);
  localparam int REM_W = mos_pkg::ROOT_W + 3;

  logic                        busy_q, done_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [mos_pkg::RAD_W-1:0]   rad_q;
  logic [REM_W-1:0]            rem_q, rem_n, trial;
  logic [mos_pkg::ROOT_W-1:0]  root_q;

  assign rem_n = {rem_q[REM_W-3:0], rad_q[mos_pkg::RAD_W-1 -: 2]};
  assign trial = REM_W'({root_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(mos_pkg::ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[mos_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[mos_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: sv/mos_apb.sv
// apb register file for the sampler settings
// depends on mos_pkg

module mos_apb (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output mos_pkg::cfg_t  cfg_o
);

  mos_pkg::cfg_t cfg_q;
  logic [1:0]    idx;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_length   <= 23'd79954;
      cfg_q.proposal_mode <= 1'b0;
      cfg_q.target_select <= 1'b0;
      cfg_q.start_coord   <= 24'sd65536;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        mos_pkg::REG_STEP_LENGTH:   cfg_q.step_length   <= pwdata[22:0];
        mos_pkg::REG_PROPOSAL_MODE: cfg_q.proposal_mode <= pwdata[0];
        mos_pkg::REG_TARGET_SELECT: cfg_q.target_select <= pwdata[0];
        mos_pkg::REG_START_COORD:   cfg_q.start_coord   <= $signed(pwdata[23:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mos_pkg::REG_STEP_LENGTH:   prdata = 32'(cfg_q.step_length);
      mos_pkg::REG_PROPOSAL_MODE: prdata = 32'(cfg_q.proposal_mode);
      mos_pkg::REG_TARGET_SELECT: prdata = 32'(cfg_q.target_select);
      mos_pkg::REG_START_COORD:   prdata = 32'(cfg_q.start_coord);
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/metropolis_orbital_sampler_step.sv
// top level: sequencer around one shared multiplier and one square root unit
// depends on mos_pkg, mos_mul, mos_isqrt, mos_apb, assert_macros.svh
//
// usage
//   input channel in_valid_i / in_stall_o carries one request: restart flag,
//   three proposal draws and the acceptance draw. output channel
//   out_valid_o / out_stall_i returns radius before the step, the accept flag
//   and the walker position after the step. settings sit on the apb port.
// sequencing
//   the two square roots run one after the other on the shared root
//   unit and the exponential walks its 16 fraction bits through the
//   shared multiplier. a new request is taken once the previous result
//   is in the output register.
// reset
//   walker goes to 1.0 on all axes, settings to their defaults, no result.
// stall
//   a result waits in the output register; if a second result is done while
//   the first is still stalled, the sequencer holds until the register frees.

`include "assert_macros.svh"

module metropolis_orbital_sampler_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mos_pkg::in_req_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mos_pkg::out_rsp_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [25:0] {
    ST_IDLE    = 26'(1) << 0,
    ST_DX      = 26'(1) << 1,
    ST_DY      = 26'(1) << 2,
    ST_DZ      = 26'(1) << 3,
    ST_SQ0     = 26'(1) << 4,
    ST_SQ1     = 26'(1) << 5,
    ST_SQ2     = 26'(1) << 6,
    ST_SQ3     = 26'(1) << 7,
    ST_SQ4     = 26'(1) << 8,
    ST_SQ5     = 26'(1) << 9,
    ST_SQ6     = 26'(1) << 10,
    ST_RO_WAIT = 26'(1) << 11,
    ST_RN_WAIT = 26'(1) << 12,
    ST_EXPM    = 26'(1) << 13,
    ST_EXPY    = 26'(1) << 14,
    ST_EXPK    = 26'(1) << 15,
    ST_EXPW    = 26'(1) << 16,
    ST_EXPE    = 26'(1) << 17,
    ST_C0      = 26'(1) << 18,
    ST_C1      = 26'(1) << 19,
    ST_C2      = 26'(1) << 20,
    ST_C3      = 26'(1) << 21,
    ST_C4      = 26'(1) << 22,
    ST_C5      = 26'(1) << 23,
    ST_C6      = 26'(1) << 24,
    ST_FIN     = 26'(1) << 25
  } state_e;

  localparam int N_W = 34 - mos_pkg::FRAC_BITS;
  localparam int K_W_L = mos_pkg::K_W;

  state_e state_q, state_d;

  mos_pkg::cfg_t     cfg;
  mos_pkg::in_req_t  req_q;
  mos_pkg::out_rsp_t out_q;
  logic              out_valid_q;

  logic signed [23:0] wx_q, wy_q, wz_q;
  logic signed [23:0] nx_q, ny_q, nz_q;
  logic [47:0]        sum_q;
  logic [23:0]        ro_q, rn_q;
  logic [31:0]        v_q;
  logic               v_one_q, ovf_q, acc_q;
  logic [4:0]         n_q;
  logic [mos_pkg::FRAC_BITS-1:0] f_q;
  logic [K_W_L-1:0]   k_q;
  logic [16:0]        e_q;
  logic [14:0]        zo_s_q, zn_s_q;
  logic [29:0]        ca_q, cb_q;
  logic [45:0]        pca_q;
  logic [48:0]        lo_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        sq_start, sq_done;
  logic [47:0] sq_rad;
  logic [23:0] sq_root;

  logic        dpos;
  logic [24:0] a_val;
  logic [N_W-1:0] n_full;
  logic [23:0] zo_abs, zn_abs, zbig;
  logic [3:0]  zsh;
  logic [5:0]  esh;
  logic [31:0] ev;
  logic [63:0] big_sum;
  logic        fbit, acc_fin, out_load;

  function automatic logic [23:0] abs24(logic signed [23:0] w);
    return w[23] ? 24'(-w) : 24'(w);
  endfunction

  function automatic logic [15:0] abs16(logic signed [15:0] d);
    return d[15] ? 16'(-d) : 16'(d);
  endfunction

  function automatic logic signed [23:0] new_coord(logic signed [23:0] w,
                                                   logic [63:0] pr,
                                                   logic neg, logic gauss);
    logic signed [39:0] sv;
    logic signed [39:0] dl;
    logic signed [40:0] s;
    sv = $signed({1'b0, pr[38:0]});
    if (neg) sv = -sv;
    dl = gauss ? (sv >>> mos_pkg::SH_GAUSS) : (sv >>> mos_pkg::SH_UNIF);
    s  = 41'(w) + 41'(dl);
    if (s > 41'(mos_pkg::COORD_MAX)) return mos_pkg::COORD_MAX;
    if (s < 41'(mos_pkg::COORD_MIN)) return mos_pkg::COORD_MIN;
    return s[23:0];
  endfunction

  mos_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mos_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  mos_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign dpos   = (rn_q >= ro_q);
  assign a_val  = cfg.target_select ? 25'(dpos ? rn_q - ro_q : ro_q - rn_q)
                                    : {(dpos ? rn_q - ro_q : ro_q - rn_q), 1'b0};
  assign n_full = prod[63:30+mos_pkg::FRAC_BITS];
  assign fbit   = f_q[mos_pkg::FRAC_BITS-1];
  assign esh    = 6'd16 + {1'b0, n_q};
  assign ev     = v_q >> esh;
  assign zo_abs = abs24(wz_q);
  assign zn_abs = abs24(nz_q);
  assign zbig   = (zo_abs > zn_abs) ? zo_abs : zn_abs;
  assign big_sum = {prod[31:0], 32'h0} + 64'(lo_q);
  assign acc_fin = (cfg.target_select && (wz_q == '0)) || acc_q;
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  // smallest shift that brings the larger |z| to 15 bits
  always_comb begin
    zsh = 4'd9;
    for (int s = 9; s >= 0; s--) begin
      if ((zbig >> s) <= 24'd32767) zsh = 4'(s);
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_DX:   begin mul_a = 32'(cfg.step_length); mul_b = 32'(abs16(req_q.draw_x)); end
      ST_DY:   begin mul_a = 32'(cfg.step_length); mul_b = 32'(abs16(req_q.draw_y)); end
      ST_DZ:   begin mul_a = 32'(cfg.step_length); mul_b = 32'(abs16(req_q.draw_z)); end
      ST_SQ0:  begin mul_a = 32'(abs24(wx_q)); mul_b = 32'(abs24(wx_q)); end
      ST_SQ1:  begin mul_a = 32'(abs24(wy_q)); mul_b = 32'(abs24(wy_q)); end
      ST_SQ2:  begin mul_a = 32'(abs24(wz_q)); mul_b = 32'(abs24(wz_q)); end
      ST_SQ3:  begin mul_a = 32'(abs24(nx_q)); mul_b = 32'(abs24(nx_q)); end
      ST_SQ4:  begin mul_a = 32'(abs24(ny_q)); mul_b = 32'(abs24(ny_q)); end
      ST_SQ5:  begin mul_a = 32'(abs24(nz_q)); mul_b = 32'(abs24(nz_q)); end
      ST_EXPM: begin mul_a = 32'(a_val); mul_b = mos_pkg::LOG2E_Q30; end
      ST_EXPK: begin mul_a = v_q; mul_b = mos_pkg::T_TAB[k_q[mos_pkg::TI_W-1:0]]; end
      ST_C0:   begin
        mul_a = cfg.target_select ? 32'(zo_s_q) : 32'd1;
        mul_b = cfg.target_select ? 32'(zo_s_q) : 32'd1;
      end
      ST_C1:   begin
        mul_a = cfg.target_select ? 32'(zn_s_q) : 32'd1;
        mul_b = cfg.target_select ? 32'(zn_s_q) : 32'd1;
      end
      ST_C2:   begin mul_a = 32'(req_q.accept_draw); mul_b = 32'(ca_q); end
      ST_C3:   begin mul_a = 32'(cb_q); mul_b = 32'(e_q); end
      ST_C4:   begin mul_a = pca_q[31:0]; mul_b = 32'(e_q); end
      ST_C5:   begin mul_a = 32'(pca_q[45:32]); mul_b = 32'(e_q); end
      default: ;
    endcase
  end

  assign sq_start = (state_q == ST_SQ4) || ((state_q == ST_RO_WAIT) && sq_done);
  assign sq_rad   = sum_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_DX;
      ST_DX:      state_d = ST_DY;
      ST_DY:      state_d = ST_DZ;
      ST_DZ:      state_d = ST_SQ0;
      ST_SQ0:     state_d = ST_SQ1;
      ST_SQ1:     state_d = ST_SQ2;
      ST_SQ2:     state_d = ST_SQ3;
      ST_SQ3:     state_d = ST_SQ4;
      ST_SQ4:     state_d = ST_SQ5;
      ST_SQ5:     state_d = ST_SQ6;
      ST_SQ6:     state_d = ST_RO_WAIT;
      ST_RO_WAIT: if (sq_done) state_d = ST_RN_WAIT;
      ST_RN_WAIT: if (sq_done) state_d = ST_EXPM;
      ST_EXPM:    state_d = ST_EXPY;
      ST_EXPY:    state_d = ST_EXPK;
      ST_EXPK: begin
        if (k_q > K_W_L'(mos_pkg::FRAC_BITS)) state_d = ST_EXPE;
        else if (fbit && !v_one_q)            state_d = ST_EXPW;
      end
      ST_EXPW:    state_d = ST_EXPK;
      ST_EXPE:    state_d = ST_C0;
      ST_C0:      state_d = ST_C1;
      ST_C1:      state_d = ST_C2;
      ST_C2:      state_d = ST_C3;
      ST_C3:      state_d = ST_C4;
      ST_C4:      state_d = dpos ? ST_FIN : ST_C5;
      ST_C5:      state_d = ST_C6;
      ST_C6:      state_d = ST_FIN;
      ST_FIN:     if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      wx_q        <= 24'sd65536;
      wy_q        <= 24'sd65536;
      wz_q        <= 24'sd65536;
    end else begin
      state_q <= state_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if ((state_q == ST_IDLE) && in_valid_i && in_data_i.restart) begin
        wx_q <= cfg.start_coord;
        wy_q <= cfg.start_coord;
        wz_q <= cfg.start_coord;
      end else if (out_load && acc_fin) begin
        wx_q <= nx_q;
        wy_q <= ny_q;
        wz_q <= nz_q;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) req_q <= in_data_i;
      ST_DY:      nx_q <= new_coord(wx_q, prod, req_q.draw_x[15], cfg.proposal_mode);
      ST_DZ:      ny_q <= new_coord(wy_q, prod, req_q.draw_y[15], cfg.proposal_mode);
      ST_SQ0:     nz_q <= new_coord(wz_q, prod, req_q.draw_z[15], cfg.proposal_mode);
      ST_SQ1:     sum_q <= prod[47:0];
      ST_SQ2:     sum_q <= sum_q + prod[47:0];
      ST_SQ3:     sum_q <= sum_q + prod[47:0];
      ST_SQ4:     sum_q <= prod[47:0];
      ST_SQ5:     sum_q <= sum_q + prod[47:0];
      ST_SQ6:     sum_q <= sum_q + prod[47:0];
      ST_RO_WAIT: if (sq_done) ro_q <= sq_root;
      ST_RN_WAIT: if (sq_done) rn_q <= sq_root;
      ST_EXPY: begin
        ovf_q   <= (n_full > N_W'(16));
        n_q     <= n_full[4:0];
        f_q     <= prod[30 +: mos_pkg::FRAC_BITS];
        v_one_q <= 1'b1;
        k_q     <= K_W_L'(1);
      end
      ST_EXPK: begin
        if ((k_q <= K_W_L'(mos_pkg::FRAC_BITS)) && !(fbit && !v_one_q)) begin
          // first set bit: v is exactly the table entry
          if (fbit) begin
            v_q     <= mos_pkg::T_TAB[k_q[mos_pkg::TI_W-1:0]];
            v_one_q <= 1'b0;
          end
          f_q <= f_q << 1;
          k_q <= k_q + K_W_L'(1);
        end
      end
      ST_EXPW: begin
        v_q <= prod[63:32];
        f_q <= f_q << 1;
        k_q <= k_q + K_W_L'(1);
      end
      ST_EXPE: begin
        if (ovf_q)        e_q <= '0;
        else if (v_one_q) e_q <= 17'(1) << (5'd16 - n_q);
        else              e_q <= ev[16:0];
        zo_s_q <= 15'(zo_abs >> zsh);
        zn_s_q <= 15'(zn_abs >> zsh);
      end
      ST_C1:      ca_q  <= prod[29:0];
      ST_C2:      cb_q  <= prod[29:0];
      ST_C3:      pca_q <= prod[45:0];
      ST_C4:      acc_q <= (64'(pca_q) < prod);
      ST_C5:      lo_q  <= prod[48:0];
      ST_C6:      acc_q <= (big_sum < {2'b00, cb_q, 32'h0});
      default: ;
    endcase
    if (out_load) begin
      out_q.radius_before <= ro_q;
      out_q.accepted      <= acc_fin;
      out_q.new_x         <= acc_fin ? nx_q : wx_q;
      out_q.new_y         <= acc_fin ? ny_q : wy_q;
      out_q.new_z         <= acc_fin ? nz_q : wz_q;
    end
  end

  `MOS_ASSERT(a_accept_starts, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> (state_q == ST_DX), "accepted request did not start the sequence")
  `MOS_ASSERT(a_sqrt_done_wait, clk_i, rst_ni, sq_done |-> (state_q == ST_RO_WAIT || state_q == ST_RN_WAIT), "root finished outside a wait state")
  `MOS_ASSERT(a_result_from_fin, clk_i, rst_ni, $rose(out_valid_o) |-> $past(state_q == ST_FIN), "result appeared without a finished step")
  `MOS_ASSERT(a_walker_moves, clk_i, rst_ni, !$stable(wx_q) |-> ($past(state_q) == ST_FIN || $past(state_q) == ST_IDLE), "walker changed mid step")

endmodule
